// ----- design/trwb_pkg.sv -----
// Shared types and constants for the TCP receive window buffer.
// Holds item kinds, result status codes, config register indexes and the result record.
// No dependencies.
package trwb_pkg;

	// Default ring size in bytes
	localparam int BUFFER_BYTES_DEF = 4096;

	// Fixed field widths of the ports
	localparam int SEQ_W      = 32;
	localparam int LEN_W      = 16;
	localparam int AVAIL_W    = 17;
	localparam int BYTE_W     = 8;
	localparam int BUF_CNT_W  = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_READER_CLOSED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEQ      = 1'd1;

	// Input item kinds
	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_FETCH   = 2'd2,
		KIND_OPEN    = 2'd3
	} kind_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_NOTHING   = 3'd0,
		ST_ACCEPTED  = 3'd1,
		ST_RESET     = 3'd2,
		ST_STALE     = 3'd3,
		ST_OVER_WIN  = 3'd4,
		ST_BYTE_READ = 3'd5,
		ST_EMPTY     = 3'd6
	} status_t;

	// One result beat
	typedef struct packed {
		status_t                status;
		logic [AVAIL_W-1:0]     available_count;
		logic [BYTE_W-1:0]      read_byte;
		logic                   need_ack;
		logic                   fin_seen;
		logic                   push_ok;
		logic [SEQ_W-1:0]       next_expected_seq;
		logic [BUF_CNT_W-1:0]   buffered_bytes;
		logic [SEQ_W-1:0]       fin_seq;
		logic [SEQ_W-1:0]       push_seq;
		logic                   wake_reader;
	} res_t;

endpackage

// ----- design/tcp_receive_window_buffer.sv -----
// Receive reassembly buffer of one TCP connection: segment checks, trim, ring store, reader fetch.
// Depends on trwb_pkg for item kinds, status codes, config indexes and the result record.
//
// The block takes one input beat in every cycle in which in_stall is low. Each beat is handled
// completely in the cycle it is accepted: header checks, state update, and either one ring
// write (payload byte) or one ring read (fetch), the ring being a single memory of BUFFER_BYTES
// bytes with one write and one read port. Header, fetch and open beats produce one result beat;
// payload beats produce none. The accepting edge loads the result stage, which passes its result
// to the output register whenever that register is empty or out_stall is low. The result stage
// lets a new beat enter while a finished result waits on a stalled output; in_stall rises only
// when both hold a result and out_stall is high. The stale, over-window, trim and in-order checks
// use the sign of the 32-bit difference.
// Ring entries read before they were ever written return arbitrary data.
module tcp_receive_window_buffer #(
	parameter int BUFFER_BYTES = trwb_pkg::BUFFER_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [trwb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trwb_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [trwb_pkg::SEQ_W-1:0]        seq_number,
	input  logic [trwb_pkg::LEN_W-1:0]        payload_length,
	input  logic                              fin_flag,
	input  logic                              push_flag,
	input  logic [trwb_pkg::BYTE_W-1:0]       data_byte,
	input  logic                              reader_waiting,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic [trwb_pkg::AVAIL_W-1:0]      available_count,
	output logic [trwb_pkg::BYTE_W-1:0]       read_byte,
	output logic                              need_ack,
	output logic                              fin_seen,
	output logic                              push_ok,
	output logic [trwb_pkg::SEQ_W-1:0]        next_expected_seq,
	output logic [trwb_pkg::BUF_CNT_W-1:0]    buffered_bytes,
	output logic [trwb_pkg::SEQ_W-1:0]        fin_seq,
	output logic [trwb_pkg::SEQ_W-1:0]        push_seq,
	output logic                              wake_reader
);

	localparam int AW    = $clog2(BUFFER_BYTES);
	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
	localparam int SW    = trwb_pkg::SEQ_W;
	localparam int LW    = trwb_pkg::LEN_W;
	localparam int OCW   = trwb_pkg::BUF_CNT_W;
	localparam logic [SW-1:0] BUF_SEQ  = SW'(BUFFER_BYTES);
	localparam logic [AW:0]   BUF_WRAP = (AW + 1)'(BUFFER_BYTES);
	localparam logic [AW-1:0] POS_LAST = AW'(BUFFER_BYTES - 1);

	// ring store
	logic [7:0] ring_q [BUFFER_BYTES];

	// connection state
	logic [AW-1:0]    rp_q, rp_d;
	logic [AW-1:0]    wp_q, wp_d;
	logic [SW-1:0]    start_q, start_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [SW-1:0]    next_q, next_d;
	logic [SW-1:0]    finseq_q, finseq_d;
	logic [SW-1:0]    pushseq_q, pushseq_d;
	logic             ack_q, ack_d;
	logic             fin_q, fin_d;
	logic             push_q, push_d;
	logic [LW-1:0]    skip_q, skip_d;
	logic [LW-1:0]    remain_q, remain_d;
	logic             acc_q, acc_d;

	// configuration registers
	logic             closed_q;
	logic [SW-1:0]    irs_q;

	// result stage and output register
	logic             valid_s1;
	trwb_pkg::res_t   res_s1;
	logic [7:0]       rd_s1;
	trwb_pkg::res_t   res_o;
	logic             out_valid_q;
	trwb_pkg::res_t   out_q;

	// per-item logic
	logic             accept;
	logic             s1_adv;
	logic             res_valid_d;
	trwb_pkg::res_t   res_d;
	trwb_pkg::kind_t  kind_in;
	logic             mem_we;

	// header datapath
	logic [SW-1:0]    len32;
	logic [SW-1:0]    end_seq;
	logic [SW-1:0]    e_sum;
	logic [SW-1:0]    d_stale;
	logic [SW-1:0]    d_over;
	logic [SW-1:0]    d_lead;
	logic [SW-1:0]    back;
	logic [SW-1:0]    d_end;
	logic [SW-1:0]    rel;
	logic [SW-1:0]    seq_off;
	logic [SW-1:0]    d_fill;
	logic             trimmed;
	logic             clip;
	logic             stale;
	logic             over;
	logic             in_order;
	logic [LW-1:0]    off;
	logic [LW-1:0]    len_t;
	logic [AW:0]      wp_sum;

	assign kind_in = trwb_pkg::kind_t'(kind);

	// handshake
	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	// segment window arithmetic
	always_comb begin
		len32   = SW'(payload_length);
		end_seq = seq_number + len32;
		e_sum   = end_seq + SW'(fin_flag);
		d_stale = e_sum - start_q;
		d_over  = e_sum - (start_q + BUF_SEQ);
		stale   = !(d_stale != '0 && !d_stale[SW-1]);
		over    = d_over != '0 && !d_over[SW-1];
		d_lead  = seq_number - start_q;
		trimmed = d_lead[SW-1];
		back    = start_q - seq_number;
		clip    = back > len32;
		d_end   = end_seq - start_q;
		off     = trimmed ? (clip ? payload_length : back[LW-1:0]) : '0;
		len_t   = payload_length - off;
		rel     = trimmed ? (clip ? d_end : '0) : d_lead;
		seq_off = trimmed ? (clip ? end_seq : start_q) : seq_number;
		d_fill  = seq_off - (start_q + SW'(cnt_q));
		in_order = !(d_fill != '0 && !d_fill[SW-1]);
		wp_sum  = {1'b0, rp_q} + rel[AW:0];
	end

	// next state and result for the item at the input
	always_comb begin
		rp_d      = rp_q;
		wp_d      = wp_q;
		start_d   = start_q;
		cnt_d     = cnt_q;
		next_d    = next_q;
		finseq_d  = finseq_q;
		pushseq_d = pushseq_q;
		ack_d     = ack_q;
		fin_d     = fin_q;
		push_d    = push_q;
		skip_d    = skip_q;
		remain_d  = remain_q;
		acc_d     = acc_q;
		mem_we    = 1'b0;
		res_valid_d = 1'b1;
		res_d     = '0;
		res_d.status = trwb_pkg::ST_NOTHING;

		case (kind_in)
			trwb_pkg::KIND_HEADER: begin
				remain_d = payload_length;
				skip_d   = '0;
				acc_d    = 1'b0;
				// record FIN
				if (fin_flag) begin
					fin_d    = 1'b1;
					finseq_d = end_seq;
				end
				if (payload_length == '0 && !fin_flag) begin
					res_d.status = trwb_pkg::ST_NOTHING;
				end else if (closed_q && payload_length != '0) begin
					res_d.status = trwb_pkg::ST_RESET;
				end else if (stale) begin
					ack_d = 1'b1;
					res_d.status = trwb_pkg::ST_STALE;
				end else if (over) begin
					ack_d = 1'b1;
					res_d.status = trwb_pkg::ST_OVER_WIN;
				end else begin
					// accept: trim, place write pointer, extend in-order data
					skip_d = off;
					acc_d  = 1'b1;
					wp_d   = (wp_sum >= BUF_WRAP) ? AW'(wp_sum - BUF_WRAP) : wp_sum[AW-1:0];
					if (in_order && d_end >= SW'(cnt_q)) begin
						cnt_d  = d_end[CNT_W-1:0];
						next_d = e_sum;
					end
					if (push_flag) begin
						push_d    = 1'b1;
						pushseq_d = end_seq;
					end
					if (len_t != '0 || fin_flag) begin
						ack_d = 1'b1;
						res_d.wake_reader = reader_waiting;
					end
					res_d.status = trwb_pkg::ST_ACCEPTED;
					res_d.available_count = trwb_pkg::AVAIL_W'(len_t) +
						trwb_pkg::AVAIL_W'(fin_flag);
				end
			end
			trwb_pkg::KIND_PAYLOAD: begin
				res_valid_d = 1'b0;
				// count off pending bytes; skip trimmed ones, store the rest
				if (remain_q != '0) begin
					remain_d = remain_q - 1'b1;
					if (skip_q != '0) begin
						skip_d = skip_q - 1'b1;
					end else if (acc_q) begin
						mem_we = 1'b1;
						wp_d   = (wp_q == POS_LAST) ? '0 : wp_q + 1'b1;
					end
					if (remain_q == LW'(1)) begin
						acc_d = 1'b0;
					end
				end
			end
			trwb_pkg::KIND_FETCH: begin
				if (cnt_q == '0) begin
					res_d.status = trwb_pkg::ST_EMPTY;
				end else begin
					rp_d    = (rp_q == POS_LAST) ? '0 : rp_q + 1'b1;
					start_d = start_q + 1'b1;
					cnt_d   = cnt_q - 1'b1;
					res_d.status = trwb_pkg::ST_BYTE_READ;
				end
			end
			trwb_pkg::KIND_OPEN: begin
				rp_d      = '0;
				wp_d      = '0;
				start_d   = irs_q;
				cnt_d     = '0;
				next_d    = irs_q;
				finseq_d  = '0;
				pushseq_d = '0;
				ack_d     = 1'b0;
				fin_d     = 1'b0;
				push_d    = 1'b0;
				skip_d    = '0;
				remain_d  = '0;
				acc_d     = 1'b0;
			end
			default: begin
				res_valid_d = 1'b0;
			end
		endcase

		// snapshot of the state after the item
		res_d.need_ack          = ack_d;
		res_d.fin_seen          = fin_d;
		res_d.push_ok           = push_d;
		res_d.next_expected_seq = next_d;
		res_d.buffered_bytes    = OCW'(cnt_d);
		res_d.fin_seq           = finseq_d;
		res_d.push_seq          = pushseq_d;
	end

	// ring write and registered ring read
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			ring_q[wp_q] <= data_byte;
		end
		if (accept) begin
			rd_s1 <= ring_q[rp_q];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= 1'b0;
			irs_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				trwb_pkg::CFG_READER_CLOSED: closed_q <= cfg_data[0];
				trwb_pkg::CFG_INIT_SEQ:      irs_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance connection state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q      <= '0;
			wp_q      <= '0;
			start_q   <= '0;
			cnt_q     <= '0;
			next_q    <= '0;
			finseq_q  <= '0;
			pushseq_q <= '0;
			ack_q     <= 1'b0;
			fin_q     <= 1'b0;
			push_q    <= 1'b0;
			skip_q    <= '0;
			remain_q  <= '0;
			acc_q     <= 1'b0;
		end else if (accept) begin
			rp_q      <= rp_d;
			wp_q      <= wp_d;
			start_q   <= start_d;
			cnt_q     <= cnt_d;
			next_q    <= next_d;
			finseq_q  <= finseq_d;
			pushseq_q <= pushseq_d;
			ack_q     <= ack_d;
			fin_q     <= fin_d;
			push_q    <= push_d;
			skip_q    <= skip_d;
			remain_q  <= remain_d;
			acc_q     <= acc_d;
		end
	end

	// result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= res_valid_d;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// merge the fetched byte into the result stage
	always_comb begin
		res_o           = res_s1;
		res_o.read_byte = (res_s1.status == trwb_pkg::ST_BYTE_READ) ? rd_s1 : '0;
	end

	// result stage and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
		if (s1_adv) begin
			out_q <= res_o;
		end
	end

	// drive the output ports
	assign out_valid         = out_valid_q;
	assign status            = out_q.status;
	assign available_count   = out_q.available_count;
	assign read_byte         = out_q.read_byte;
	assign need_ack          = out_q.need_ack;
	assign fin_seen          = out_q.fin_seen;
	assign push_ok           = out_q.push_ok;
	assign next_expected_seq = out_q.next_expected_seq;
	assign buffered_bytes    = out_q.buffered_bytes;
	assign fin_seq           = out_q.fin_seq;
	assign push_seq          = out_q.push_seq;
	assign wake_reader       = out_q.wake_reader;

endmodule

// ----- tb/sv/tb_tcp_receive_window_buffer.sv -----
// Self-checking testbench for the TCP receive window buffer.
// Drives directed and random segment, payload, fetch and open beats and checks every result
// beat against an in-bench window model. Depends on trwb_pkg and tcp_receive_window_buffer.
module tb_tcp_receive_window_buffer;

	localparam int RING        = trwb_pkg::BUFFER_BYTES_DEF;
	localparam int STALL_LIMIT = 4000;

	// One input beat as seen on the ports
	typedef struct {
		trwb_pkg::kind_t kind;
		logic [31:0]     seq;
		logic [15:0]     len;
		logic            fin;
		logic            psh;
		logic [7:0]      data;
		logic            waiting;
	} rx_item_t;

	// Window model plus the queue of result beats it still owes
	class rx_window_scoreboard;
		logic [7:0]      ring [RING];
		bit              filled [RING];
		int              rd_pos;
		int              wr_pos;
		logic [31:0]     start_seq;
		logic [31:0]     next_seq;
		logic [31:0]     fin_sq;
		logic [31:0]     push_sq;
		logic [12:0]     buffered;
		logic            ack_due;
		logic            fin_rcvd;
		logic            pushed;
		logic [15:0]     skip_left;
		logic [15:0]     bytes_left;
		logic            storing;
		logic            closed;
		logic [31:0]     init_seq;
		trwb_pkg::res_t  expected_q [$];
		int              errors;
		int              reports;

		function new();
			foreach (filled[i])
				filled[i] = 1'b0;
			closed   = 1'b0;
			init_seq = '0;
			errors   = 0;
			reports  = 0;
			restart(32'd0);
		endfunction

		function void restart(logic [31:0] first);
			rd_pos     = 0;
			wr_pos     = 0;
			start_seq  = first;
			next_seq   = first;
			buffered   = '0;
			fin_sq     = '0;
			push_sq    = '0;
			ack_due    = 1'b0;
			fin_rcvd   = 1'b0;
			pushed     = 1'b0;
			skip_left  = '0;
			bytes_left = '0;
			storing    = 1'b0;
		endfunction

		function void load_reg(logic [trwb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
			if (idx == trwb_pkg::CFG_READER_CLOSED)
				closed = value[0];
			else if (idx == trwb_pkg::CFG_INIT_SEQ)
				init_seq = value;
		endfunction

		// signed 32-bit sequence compares
		function bit seq_after(logic [31:0] a, logic [31:0] b);
			logic [31:0] d;
			d = a - b;
			return d != 0 && !d[31];
		endfunction

		function bit seq_before(logic [31:0] a, logic [31:0] b);
			logic [31:0] d;
			d = a - b;
			return d[31];
		endfunction

		function bit fetch_safe();
			return buffered == 0 || filled[rd_pos];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function trwb_pkg::res_t snapshot(trwb_pkg::status_t st, logic [16:0] avail,
				logic [7:0] b, logic wake);
			trwb_pkg::res_t r;
			r.status            = st;
			r.available_count   = avail;
			r.read_byte         = b;
			r.need_ack          = ack_due;
			r.fin_seen          = fin_rcvd;
			r.push_ok           = pushed;
			r.next_expected_seq = next_seq;
			r.buffered_bytes    = buffered;
			r.fin_seq           = fin_sq;
			r.push_seq          = push_sq;
			r.wake_reader       = wake;
			return r;
		endfunction

		// Advance the window on one accepted beat and queue the result it owes
		function void note_beat(rx_item_t it);
			logic [31:0]       tail;
			logic [31:0]       off;
			logic [31:0]       rel;
			logic [31:0]       endseq;
			logic [16:0]       avail;
			logic [7:0]        b;
			logic              wake;
			trwb_pkg::status_t st;
			avail = '0;
			wake  = 1'b0;
			case (it.kind)
				trwb_pkg::KIND_HEADER: begin
					bytes_left = it.len;
					skip_left  = '0;
					storing    = 1'b0;
					if (it.fin) begin
						fin_rcvd = 1'b1;
						fin_sq   = it.seq + 32'(it.len);
					end
					tail = it.seq + 32'(it.len) + 32'(it.fin);
					if (it.len == 0 && !it.fin) begin
						st = trwb_pkg::ST_NOTHING;
					end else if (closed && it.len != 0) begin
						st = trwb_pkg::ST_RESET;
					end else if (!seq_after(tail, start_seq)) begin
						ack_due = 1'b1;
						st      = trwb_pkg::ST_STALE;
					end else if (seq_after(tail, start_seq + 32'(RING))) begin
						ack_due = 1'b1;
						st      = trwb_pkg::ST_OVER_WIN;
					end else begin
						// trim bytes the reader already consumed
						off = '0;
						if (seq_before(it.seq, start_seq)) begin
							off = start_seq - it.seq;
							if (off > 32'(it.len))
								off = 32'(it.len);
						end
						skip_left = off[15:0];
						storing   = 1'b1;
						rel       = it.seq + off - start_seq;
						wr_pos    = int'((64'(rd_pos) + 64'(rel)) % 64'(RING));
						endseq    = it.seq + 32'(it.len);
						// extend the in-order run only when the segment touches it
						if (!seq_after(it.seq + off, start_seq + 32'(buffered))
								&& endseq - start_seq >= 32'(buffered)) begin
							buffered = 13'(endseq - start_seq);
							next_seq = endseq + 32'(it.fin);
						end
						if (it.psh) begin
							pushed  = 1'b1;
							push_sq = endseq;
						end
						if (32'(it.len) != off || it.fin) begin
							ack_due = 1'b1;
							wake    = it.waiting;
						end
						st    = trwb_pkg::ST_ACCEPTED;
						avail = 17'(32'(it.len) - off) + 17'(it.fin);
					end
					expected_q.push_back(snapshot(st, avail, 8'h00, wake));
				end
				trwb_pkg::KIND_PAYLOAD: begin
					if (bytes_left != 0) begin
						bytes_left--;
						if (skip_left != 0) begin
							skip_left--;
						end else if (storing) begin
							ring[wr_pos]   = it.data;
							filled[wr_pos] = 1'b1;
							wr_pos         = (wr_pos + 1) % RING;
						end
						if (bytes_left == 0)
							storing = 1'b0;
					end
				end
				trwb_pkg::KIND_FETCH: begin
					if (buffered == 0) begin
						expected_q.push_back(snapshot(trwb_pkg::ST_EMPTY, '0, 8'h00, 1'b0));
					end else begin
						b         = ring[rd_pos];
						rd_pos    = (rd_pos + 1) % RING;
						start_seq = start_seq + 32'd1;
						buffered  = buffered - 13'd1;
						expected_q.push_back(snapshot(trwb_pkg::ST_BYTE_READ, '0, b, 1'b0));
					end
				end
				default: begin
					restart(init_seq);
					expected_q.push_back(snapshot(trwb_pkg::ST_NOTHING, '0, 8'h00, 1'b0));
				end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (reports < 10) begin
					reports++;
					$display("mismatch on %s: expected %0h, got %0h", name, want, got);
				end
			end
		endfunction

		// Match one result beat against the oldest owed result
		function void check_result(trwb_pkg::res_t got);
			trwb_pkg::res_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (reports < 10) begin
					reports++;
					$display("unexpected result beat: status %0d", got.status);
				end
				return;
			end
			want = expected_q.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("available_count", 32'(want.available_count),
				32'(got.available_count));
			compare_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
			compare_field("need_ack", 32'(want.need_ack), 32'(got.need_ack));
			compare_field("fin_seen", 32'(want.fin_seen), 32'(got.fin_seen));
			compare_field("push_ok", 32'(want.push_ok), 32'(got.push_ok));
			compare_field("next_expected_seq", want.next_expected_seq, got.next_expected_seq);
			compare_field("buffered_bytes", 32'(want.buffered_bytes), 32'(got.buffered_bytes));
			compare_field("fin_seq", want.fin_seq, got.fin_seq);
			compare_field("push_seq", want.push_seq, got.push_seq);
			compare_field("wake_reader", 32'(want.wake_reader), 32'(got.wake_reader));
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [trwb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [trwb_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_stall;
	logic [1:0]                      kind;
	logic [trwb_pkg::SEQ_W-1:0]      seq_number;
	logic [trwb_pkg::LEN_W-1:0]      payload_length;
	logic                            fin_flag;
	logic                            push_flag;
	logic [trwb_pkg::BYTE_W-1:0]     data_byte;
	logic                            reader_waiting;
	logic                            out_valid;
	logic                            out_stall;
	logic [2:0]                      status;
	logic [trwb_pkg::AVAIL_W-1:0]    available_count;
	logic [trwb_pkg::BYTE_W-1:0]     read_byte;
	logic                            need_ack;
	logic                            fin_seen;
	logic                            push_ok;
	logic [trwb_pkg::SEQ_W-1:0]      next_expected_seq;
	logic [trwb_pkg::BUF_CNT_W-1:0]  buffered_bytes;
	logic [trwb_pkg::SEQ_W-1:0]      fin_seq;
	logic [trwb_pkg::SEQ_W-1:0]      push_seq;
	logic                            wake_reader;

	rx_window_scoreboard sb;
	int                  send_idle;
	int                  recv_idle;
	int                  idle_cycles;
	int unsigned         items_sent;

	tcp_receive_window_buffer dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.kind              (kind),
		.seq_number        (seq_number),
		.payload_length    (payload_length),
		.fin_flag          (fin_flag),
		.push_flag         (push_flag),
		.data_byte         (data_byte),
		.reader_waiting    (reader_waiting),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.available_count   (available_count),
		.read_byte         (read_byte),
		.need_ack          (need_ack),
		.fin_seen          (fin_seen),
		.push_ok           (push_ok),
		.next_expected_seq (next_expected_seq),
		.buffered_bytes    (buffered_bytes),
		.fin_seq           (fin_seq),
		.push_seq          (push_seq),
		.wake_reader       (wake_reader)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Note accepted input beats first, then check accepted result beats
	always @(posedge clk) begin : monitor_blk
		rx_item_t       seen;
		trwb_pkg::res_t got;
		bit             moved;
		moved = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			seen.kind    = trwb_pkg::kind_t'(kind);
			seen.seq     = seq_number;
			seen.len     = payload_length;
			seen.fin     = fin_flag;
			seen.psh     = push_flag;
			seen.data    = data_byte;
			seen.waiting = reader_waiting;
			sb.note_beat(seen);
			moved = 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			got.status            = trwb_pkg::status_t'(status);
			got.available_count   = available_count;
			got.read_byte         = read_byte;
			got.need_ack          = need_ack;
			got.fin_seen          = fin_seen;
			got.push_ok           = push_ok;
			got.next_expected_seq = next_expected_seq;
			got.buffered_bytes    = buffered_bytes;
			got.fin_seq           = fin_seq;
			got.push_seq          = push_seq;
			got.wake_reader       = wake_reader;
			sb.check_result(got);
			moved = 1'b1;
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
	end

	// End the run when nothing has moved for too long
	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// Offer one beat, idling first at random, and hold it until accepted
	task automatic send_item(trwb_pkg::kind_t k, logic [31:0] s, logic [15:0] l, logic f,
			logic p, logic [7:0] d, logic w);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind           = k;
		seq_number     = s;
		payload_length = l;
		fin_flag       = f;
		push_flag      = p;
		data_byte      = d;
		reader_waiting = w;
		in_valid       = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	// Send a beat whose unused fields carry noise
	task automatic send_other(trwb_pkg::kind_t k);
		send_item(k, $urandom, 16'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
			1'($urandom));
	endtask

	// Send a header and the first n of its payload beats
	task automatic send_segment(logic [31:0] s, logic [15:0] l, logic f, logic p,
			int unsigned n);
		send_item(trwb_pkg::KIND_HEADER, s, l, f, p, 8'($urandom), 1'($urandom));
		repeat (n)
			send_item(trwb_pkg::KIND_PAYLOAD, $urandom, 16'($urandom), 1'($urandom),
				1'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// Fetch one byte; refill the head of the ring first if it was never written
	task automatic send_fetch();
		int unsigned n;
		if (!sb.fetch_safe()) begin
			n = (sb.buffered > 40) ? 40 : int'(sb.buffered);
			send_segment(sb.start_seq, 16'(n), 1'b0, 1'b0, n);
		end
		if (sb.fetch_safe())
			send_other(trwb_pkg::KIND_FETCH);
	endtask

	// Hold the sender until every owed result is back and the block is quiet
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(logic [trwb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.load_reg(idx, value);
	endtask

	initial begin
		logic [31:0] first_seqs [6];
		logic [31:0] base;
		int unsigned goal;
		int unsigned pick;
		int unsigned l;
		int unsigned k;
		int unsigned n;
		logic        f;
		logic        p;
		sb             = new();
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		kind           = trwb_pkg::KIND_HEADER;
		seq_number     = '0;
		payload_length = '0;
		fin_flag       = 1'b0;
		push_flag      = 1'b0;
		data_byte      = '0;
		reader_waiting = 1'b0;
		items_sent     = 0;
		send_idle      = 19;
		recv_idle      = 51;
		first_seqs     = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_F000, $urandom};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: start just below the sequence wrap
		cfg_write(trwb_pkg::CFG_READER_CLOSED, 32'd0);
		cfg_write(trwb_pkg::CFG_INIT_SEQ, 32'hFFFF_FFFC);
		send_other(trwb_pkg::KIND_OPEN);
		send_fetch();
		send_segment(32'hFFFF_FFFF, 16'd0, 1'b0, 1'b0, 0);
		// in-order data across the wrap, extreme byte values first
		send_item(trwb_pkg::KIND_HEADER, sb.start_seq, 16'd5, 1'b0, 1'b1, 8'h00, 1'b1);
		send_item(trwb_pkg::KIND_PAYLOAD, '0, '0, 1'b0, 1'b0, 8'h00, 1'b0);
		send_item(trwb_pkg::KIND_PAYLOAD, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 1'b1);
		send_segment(sb.start_seq + 32'd5, 16'd0, 1'b0, 1'b0, 0);
		repeat (3)
			send_other(trwb_pkg::KIND_PAYLOAD);
		send_other(trwb_pkg::KIND_PAYLOAD);
		send_fetch();
		send_fetch();
		// stale, over the window, and the last byte the window allows
		send_segment(sb.start_seq - 32'd10, 16'd5, 1'b0, 1'b0, 1);
		send_segment(sb.start_seq + 32'd4090, 16'd20, 1'b0, 1'b0, 1);
		send_segment(sb.start_seq + 32'd4095, 16'd1, 1'b0, 1'b0, 0);
		// overlap with consumed bytes, then FIN
		send_segment(sb.start_seq - 32'd2, 16'd4, 1'b0, 1'b1, 4);
		send_segment(sb.start_seq + 32'(sb.buffered), 16'd0, 1'b1, 1'b0, 0);
		// header arriving before the previous segment is complete
		send_segment(sb.start_seq + 32'(sb.buffered), 16'd5, 1'b0, 1'b0, 2);
		send_segment(sb.start_seq + 32'(sb.buffered), 16'd2, 1'b0, 1'b0, 2);
		// longest segment, nearly all of it already consumed
		send_segment(sb.start_seq - 32'd65000, 16'hFFFF, 1'b0, 1'b0, 1);
		// closed reader: data means reset, a bare FIN does not
		settle();
		cfg_write(trwb_pkg::CFG_READER_CLOSED, 32'd1);
		send_segment(sb.start_seq + 32'(sb.buffered), 16'd3, 1'b0, 1'b0, 1);
		send_segment(sb.start_seq + 32'(sb.buffered), 16'd0, 1'b1, 1'b0, 0);

		// Random phases, each on a fresh connection
		for (int ph = 0; ph < 6; ph++) begin
			send_idle = (ph < 2) ? 19 : (ph < 4) ? 51 : 0;
			recv_idle = (ph < 2) ? 51 : (ph < 4) ? 19 : 0;
			settle();
			cfg_write(trwb_pkg::CFG_READER_CLOSED, (ph == 3) ? 32'd1 : 32'd0);
			cfg_write(trwb_pkg::CFG_INIT_SEQ, first_seqs[ph]);
			send_other(trwb_pkg::KIND_OPEN);
			goal = items_sent + 200;
			while (items_sent < goal) begin
				pick = $urandom_range(99);
				l    = ($urandom_range(9) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 12);
				n    = ($urandom_range(19) == 0) ? $urandom_range(0, l) : l;
				f    = ($urandom_range(15) == 0);
				p    = ($urandom_range(2) == 0);
				base = ($urandom_range(3) == 0) ? sb.next_seq : sb.start_seq + 32'(sb.buffered);
				if (pick < 38) begin
					send_segment(base, 16'(l), f, p, n);
				end else if (pick < 48) begin
					// out of order: leave a hole
					send_segment(base + $urandom_range(1, 60), 16'(l), f, p, n);
				end else if (pick < 56) begin
					// retransmit overlapping consumed bytes
					k = $urandom_range(1, 30);
					send_segment(sb.start_seq - k, 16'(k + l), f, p, k + l);
				end else if (pick < 61) begin
					send_segment(sb.start_seq - l - $urandom_range(1, 100), 16'(l), f, p, n);
				end else if (pick < 66) begin
					send_segment(sb.start_seq + $urandom_range(4097, 70000), 16'(l), f, p, n);
				end else if (pick < 89) begin
					repeat ($urandom_range(1, 6))
						send_fetch();
				end else if (pick < 92) begin
					send_segment($urandom, 16'($urandom), f, p, $urandom_range(0, 3));
				end else if (pick < 94) begin
					send_segment(sb.start_seq - $urandom_range(0, 65535), 16'($urandom), f, p,
						$urandom_range(0, 3));
				end else if (pick < 96) begin
					send_other(trwb_pkg::KIND_PAYLOAD);
				end else if (pick < 98) begin
					send_other(trwb_pkg::KIND_OPEN);
				end else begin
					settle();
				end
			end
		end

		// Drain, then allow for stray results
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
